// ===== rtl/core/window2x2_sum_threshold_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the 2x2 window sum block
// Shared property forms; the user supplies i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef WINDOW2X2_SUM_THRESHOLD_TOP_ASSERT_SVH
`define WINDOW2X2_SUM_THRESHOLD_TOP_ASSERT_SVH

// same-cycle implication, masked during reset
`define W2S_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define W2S_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define W2S_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/w2s_pkg.sv =====
// ----------------------------------------------------------------------------
// w2s_pkg
// Types and constants shared by the 2x2 window sum modules.
// ----------------------------------------------------------------------------
package w2s_pkg;

    // element and result widths
    localparam int VAL_W     = 32;
    localparam int SUM_W     = 34;
    localparam int WIN_IDX_W = 10;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int SIZE_W     = 11;
    localparam int SIZE_RST   = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd2;

    // stream payload widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 56;

    // queue between front and back
    localparam int QDEPTH = 4;

    // one window waiting to be summed
    typedef struct packed {
        logic [VAL_W-1:0]     left_above;
        logic [VAL_W-1:0]     above;
        logic [VAL_W-1:0]     left_here;
        logic [VAL_W-1:0]     value;
        logic [WIN_IDX_W-1:0] row;
        logic [WIN_IDX_W-1:0] col;
    } t_win_entry;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_stat;

endpackage

// ===== rtl/core/window2x2_sum_threshold_top.sv =====
// ----------------------------------------------------------------------------
// window2x2_sum_threshold_top
// 2x2 sliding window sum with threshold flag over a row-major element stream.
// ----------------------------------------------------------------------------
// Usage:
//   Elements enter on the s_axis channel, one signed 32-bit value per transfer,
//   in row-major order. For every element at row >= 1 and column >= 1 one
//   result leaves on m_axis: window top-left row/column, the 34-bit sum of the
//   four elements and a hit flag (sum greater than threshold) in tuser.
//   Elements in the first row or column give no result.
//   Registers (threshold, columns, rows) are written through the cfg channel,
//   index 0..2, while the stream is idle; o_cfg_ready is always high.
//   Throughput is one element per cycle unless the window queue is full; the
//   line buffer is one RAM with a read and a write port, both used once per
//   element at the column address. From input transfer to m_axis_tvalid the
//   steps are line buffer read, queue, pairwise add, final add, then the
//   compare into the output register.
//   Reset clears the counters, left neighbors and registers at once; there is
//   no clearing pass, the line buffer is filled by the first row.
//   When the receiver stalls, the back pipeline holds and a four-entry queue
//   absorbs windows before s_axis_tready drops.
// ----------------------------------------------------------------------------
module window2x2_sum_threshold_top
    import w2s_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // element input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [31:0] value
    // result output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [9:0] win_row, [19:10] win_col,
                                                  // [53:20] win_sum, [55:54] zero
    output logic                  m_axis_tuser,   // [0] hit
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_win_entry           push_entry;
    t_win_entry           pop_entry;
    t_q_stat              qstat;
    logic                 push;
    logic                 pop;
    logic [VAL_W-1:0]     threshold;
    logic [WIN_IDX_W-1:0] win_row;
    logic [WIN_IDX_W-1:0] win_col;
    logic [SUM_W-1:0]     win_sum;
    logic                 hit;

    assign o_cfg_ready = 1'b1;

    // position tracking and line buffer
    w2s_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (s_axis_tvalid),
        .o_s_ready   (s_axis_tready),
        .i_s_value   (s_axis_tdata[VAL_W-1:0]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_threshold (threshold),
        .o_push      (push),
        .o_entry     (push_entry),
        .i_qstat     (qstat)
    );

    // window queue
    w2s_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_entry),
        .i_pop       (pop),
        .o_pop_data  (pop_entry),
        .o_stat      (qstat)
    );

    // sum and compare
    w2s_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (qstat),
        .i_entry     (pop_entry),
        .o_pop       (pop),
        .i_threshold (threshold),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_win_row   (win_row),
        .o_win_col   (win_col),
        .o_win_sum   (win_sum),
        .o_hit       (hit)
    );

    assign m_axis_tdata = {{(M_TDATA_W-SUM_W-2*WIN_IDX_W){1'b0}}, win_sum, win_col, win_row};
    assign m_axis_tuser = hit;

endmodule

// ===== rtl/core/w2s_ram.sv =====
// ----------------------------------------------------------------------------
// w2s_ram
// Generic single-write, single-read RAM with registered read data.
// A read at the address written in the same cycle returns the old data.
// ----------------------------------------------------------------------------
module w2s_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read before write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/w2s_fifo.sv =====
// ----------------------------------------------------------------------------
// w2s_fifo
// Short register queue that decouples window classification from summing.
// ----------------------------------------------------------------------------
module w2s_fifo
    import w2s_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_win_entry i_push_data,
    input  logic       i_pop,
    output t_win_entry o_pop_data,
    output t_q_stat    o_stat
);

    localparam int PW = $clog2(QDEPTH);

    t_win_entry   r_buf [QDEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [PW:0]   r_count, n_count;
    logic          push_ok;
    logic          pop_ok;

    assign push_ok = i_push && (r_count != (PW+1)'(QDEPTH));
    assign pop_ok  = i_pop && (r_count != '0);

    // pointer and fill count
    always_comb begin
        n_wr_ptr = push_ok ? r_wr_ptr + PW'(1) : r_wr_ptr;
        n_rd_ptr = pop_ok ? r_rd_ptr + PW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + (PW+1)'(1);
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - (PW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_buf[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_pop_data       = r_buf[r_rd_ptr];
    assign o_stat.full      = (r_count == (PW+1)'(QDEPTH));
    assign o_stat.not_empty = (r_count != '0);

endmodule

// ===== rtl/core/w2s_front.sv =====
// ----------------------------------------------------------------------------
// w2s_front
// Accepts elements, tracks the matrix position, reads and refills the line
// buffer, and queues one window for every element past the first row/column.
// Also holds the configuration registers.
// ----------------------------------------------------------------------------
module w2s_front
    import w2s_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // element input
    input  logic                  i_s_valid,
    output logic                  o_s_ready,
    input  logic [VAL_W-1:0]      i_s_value,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [VAL_W-1:0]      o_threshold,
    // queue side
    output logic                  o_push,
    output t_win_entry            o_entry,
    input  t_q_stat               i_qstat
);

    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CXW = (CW > WIN_IDX_W) ? CW : WIN_IDX_W;
    localparam int RXW = (RW > WIN_IDX_W) ? RW : WIN_IDX_W;
    localparam int RST_COL_LAST = ((SIZE_RST > MAX_COLS) ? MAX_COLS : SIZE_RST) - 1;
    localparam int RST_ROW_LAST = ((SIZE_RST > MAX_ROWS) ? MAX_ROWS : SIZE_RST) - 1;

    // size register to last index; zero counts as one, too big counts as max
    function automatic int size_last(input logic [SIZE_W-1:0] sz, input int max_sz);
        int last;
        if (sz == '0) begin
            last = 0;
        end else if (int'(sz) > max_sz) begin
            last = max_sz - 1;
        end else begin
            last = int'(sz) - 1;
        end
        return last;
    endfunction

    logic [VAL_W-1:0] r_threshold;
    logic [CW-1:0]    r_col_last;
    logic [RW-1:0]    r_row_last;
    logic [CW-1:0]    r_col, n_col;
    logic [RW-1:0]    r_row, n_row;
    logic             r_s1_valid;
    logic [VAL_W-1:0] r_s1_value;
    logic [CW-1:0]    r_s1_col;
    logic [RW-1:0]    r_s1_row;
    logic [VAL_W-1:0] r_left_here;
    logic [VAL_W-1:0] r_left_above;
    logic [VAL_W-1:0] above;
    logic [CXW-1:0]   col_ext;
    logic [RXW-1:0]   row_ext;
    logic             accept;
    logic             s1_has;
    logic             s1_go;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_col_last  <= CW'(RST_COL_LAST);
            r_row_last  <= RW'(RST_ROW_LAST);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_COLS:      r_col_last  <= CW'(size_last(i_cfg_data[SIZE_W-1:0], MAX_COLS));
                CFG_ROWS:      r_row_last  <= RW'(size_last(i_cfg_data[SIZE_W-1:0], MAX_ROWS));
                default: begin
                end
            endcase
        end
    end

    assign o_threshold = r_threshold;

    // handshake: stage 1 leaves at once if it has no window
    assign s1_has    = (r_s1_row != '0) && (r_s1_col != '0);
    assign s1_go     = r_s1_valid && (!s1_has || !i_qstat.full);
    assign o_s_ready = !r_s1_valid || s1_go;
    assign accept    = i_s_valid && o_s_ready;

    // position counters, wrap at or past the last position
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (r_col >= r_col_last) begin
            n_col = '0;
            n_row = (r_row >= r_row_last) ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line buffer: read the element above, store the new one, same address
    w2s_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_COLS)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata (i_s_value),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (above)
    );

    // stage 1 holds the element while the line buffer read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_ready) begin
            r_s1_valid <= i_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_value <= i_s_value;
            r_s1_col   <= r_col;
            r_s1_row   <= r_row;
        end
    end

    // left neighbors advance once per element, in order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_here  <= '0;
            r_left_above <= '0;
        end else if (s1_go) begin
            r_left_here  <= r_s1_value;
            r_left_above <= above;
        end
    end

    // window top-left coordinates
    assign col_ext = CXW'(r_s1_col) - CXW'(1);
    assign row_ext = RXW'(r_s1_row) - RXW'(1);

    assign o_push             = r_s1_valid && s1_has && !i_qstat.full;
    assign o_entry.left_above = r_left_above;
    assign o_entry.above      = above;
    assign o_entry.left_here  = r_left_here;
    assign o_entry.value      = r_s1_value;
    assign o_entry.row        = row_ext[WIN_IDX_W-1:0];
    assign o_entry.col        = col_ext[WIN_IDX_W-1:0];

endmodule

// ===== rtl/core/w2s_back.sv =====
// ----------------------------------------------------------------------------
// w2s_back
// Sums queued windows in two add stages, compares against the threshold and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module w2s_back
    import w2s_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // queue side
    input  t_q_stat              i_qstat,
    input  t_win_entry           i_entry,
    output logic                 o_pop,
    input  logic [VAL_W-1:0]     i_threshold,
    // result output
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [WIN_IDX_W-1:0] o_win_row,
    output logic [WIN_IDX_W-1:0] o_win_col,
    output logic [SUM_W-1:0]     o_win_sum,
    output logic                 o_hit
);

    logic                 r_b1_valid;
    logic [VAL_W:0]       r_b1_top;
    logic [VAL_W:0]       r_b1_bot;
    logic [WIN_IDX_W-1:0] r_b1_row;
    logic [WIN_IDX_W-1:0] r_b1_col;
    logic                 r_b2_valid;
    logic [SUM_W-1:0]     r_b2_sum;
    logic [WIN_IDX_W-1:0] r_b2_row;
    logic [WIN_IDX_W-1:0] r_b2_col;
    logic                 r_o_valid;
    logic [SUM_W-1:0]     r_o_sum;
    logic [WIN_IDX_W-1:0] r_o_row;
    logic [WIN_IDX_W-1:0] r_o_col;
    logic                 r_o_hit;
    logic                 o_load;
    logic                 b2_ready;
    logic                 b1_ready;

    // per-stage ready chain
    assign o_load   = !r_o_valid || i_ready;
    assign b2_ready = !r_b2_valid || o_load;
    assign b1_ready = !r_b1_valid || b2_ready;
    assign o_pop    = i_qstat.not_empty && b1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (b1_ready) begin
                r_b1_valid <= i_qstat.not_empty;
            end
            if (b2_ready) begin
                r_b2_valid <= r_b1_valid;
            end
            if (o_load) begin
                r_o_valid <= r_b2_valid;
            end
        end
    end

    // pairwise sums, sign extended
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b1_top <= {i_entry.left_above[VAL_W-1], i_entry.left_above}
                      + {i_entry.above[VAL_W-1], i_entry.above};
            r_b1_bot <= {i_entry.left_here[VAL_W-1], i_entry.left_here}
                      + {i_entry.value[VAL_W-1], i_entry.value};
            r_b1_row <= i_entry.row;
            r_b1_col <= i_entry.col;
        end
    end

    // full window sum
    always_ff @(posedge i_clk) begin
        if (r_b1_valid && b2_ready) begin
            r_b2_sum <= {r_b1_top[VAL_W], r_b1_top} + {r_b1_bot[VAL_W], r_b1_bot};
            r_b2_row <= r_b1_row;
            r_b2_col <= r_b1_col;
        end
    end

    // threshold compare into the output register
    always_ff @(posedge i_clk) begin
        if (r_b2_valid && o_load) begin
            r_o_sum <= r_b2_sum;
            r_o_row <= r_b2_row;
            r_o_col <= r_b2_col;
            r_o_hit <= $signed(r_b2_sum) > $signed({{(SUM_W-VAL_W){i_threshold[VAL_W-1]}},
                                                    i_threshold});
        end
    end

    assign o_valid   = r_o_valid;
    assign o_win_row = r_o_row;
    assign o_win_col = r_o_col;
    assign o_win_sum = r_o_sum;
    assign o_hit     = r_o_hit;

endmodule

// ===== rtl/core/w2s_checker.sv =====
// ----------------------------------------------------------------------------
// w2s_checker
// Port-level checks for the 2x2 window sum block, bound to the top level.
// ----------------------------------------------------------------------------
`include "window2x2_sum_threshold_top_assert.svh"

module w2s_checker
    import w2s_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [S_TDATA_W-1:0]  s_axis_tdata,   // [31:0] value
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [M_TDATA_W-1:0]  m_axis_tdata,   // [9:0] row, [19:10] col, [53:20] sum
    input logic                  m_axis_tuser,   // [0] hit
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [VAL_W-1:0] r_thr;
    logic             thr_ok;
    logic             stalled;

    // shadow copy of the threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_THRESHOLD)) begin
            r_thr <= i_cfg_data;
        end
    end

    assign thr_ok  = m_axis_tuser == ($signed(m_axis_tdata[53:20])
                   > $signed({{(SUM_W-VAL_W){r_thr[VAL_W-1]}}, r_thr}));
    assign stalled = m_axis_tvalid && !m_axis_tready;

    `W2S_ASSERT_NEXT(a_hold_valid, stalled, m_axis_tvalid, "result dropped while stalled")
    `W2S_ASSERT_NEXT(a_hold_data, stalled, $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "result changed while stalled")
    `W2S_ASSERT_NOW(a_hit_flag, m_axis_tvalid, thr_ok, "hit flag disagrees with sum")
    `W2S_ASSERT_RST(a_reset_empty, !i_rst_n, !m_axis_tvalid, "result valid after reset")

endmodule

bind window2x2_sum_threshold_top w2s_checker u_chk (.*);

// ===== test/tb_window2x2_sum_threshold_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_window2x2_sum_threshold_top
// Stream test of the 2x2 window sum block. A queue of matrix elements feeds a
// clocked driver. A clocked monitor runs an in-bench line-buffer model on
// every accepted element and checks each result transfer against the oldest
// predicted window. Register writes happen only between phases, once the
// stream has drained. The phases cover a directed set, a wide two-row matrix,
// and random sizes and thresholds with mid-matrix resizing.
// ----------------------------------------------------------------------------
module tb_window2x2_sum_threshold_top;
    import w2s_pkg::*;

    localparam int COL_LIMIT     = 1024;
    localparam int ROW_LIMIT     = 1024;
    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_ITEMS  = 480;
    localparam int WIDE_COLS     = 150;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [VAL_W-1:0]     VAL_MAX   = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0]     VAL_MIN   = 32'h8000_0000;

    typedef enum int {VALS_WIDE, VALS_NEAR_ZERO, VALS_EDGE, VALS_MIXED} value_mix_t;

    // one predicted window result
    typedef struct packed {
        logic [WIN_IDX_W-1:0]    row;
        logic [WIN_IDX_W-1:0]    col;
        logic signed [SUM_W-1:0] sum;
        logic                    hit;
    } window_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;   // [31:0] value
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;   // [9:0] win_row, [19:10] win_col,
                                           // [53:20] win_sum, [55:54] zero
    logic                  m_axis_tuser;   // [0] hit
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // line buffer model state
    logic signed [VAL_W-1:0] line_buf [COL_LIMIT];
    logic signed [VAL_W-1:0] left_here     = '0;
    logic signed [VAL_W-1:0] left_above    = '0;
    int                      col_pos       = 0;
    int                      row_pos       = 0;
    int                      line_filled   = 0;   // entries 0..line_filled-1 written
    logic signed [VAL_W-1:0] threshold_reg = '0;
    logic [SIZE_W-1:0]       cols_reg      = SIZE_W'(SIZE_RST);
    logic [SIZE_W-1:0]       rows_reg      = SIZE_W'(SIZE_RST);

    logic [S_TDATA_W-1:0] elem_queue [$];
    window_t              window_q   [$];
    int                   elems_queued = 0;
    int                   elems_taken  = 0;
    logic                 elem_taken   = 1'b0;
    int                   mismatches   = 0;
    int                   tx_idle_pct  = 37;
    int                   rx_idle_pct  = 62;

    window2x2_sum_threshold_top #(
        .MAX_COLS(COL_LIMIT),
        .MAX_ROWS(ROW_LIMIT)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // size register as the block uses it: zero means one, clamp at the limit
    function automatic int size_eff(input logic [SIZE_W-1:0] raw, input int limit);
        if (raw == 0)
            return 1;
        if (int'(raw) > limit)
            return limit;
        return int'(raw);
    endfunction

    // advance the line buffer model by one element, queue any window it closes
    function automatic void predict_window(input logic [VAL_W-1:0] value);
        int                      n_cols;
        int                      n_rows;
        logic signed [VAL_W-1:0] above;
        longint                  total;
        window_t                 w;
        n_cols = size_eff(cols_reg, COL_LIMIT);
        n_rows = size_eff(rows_reg, ROW_LIMIT);
        above  = line_buf[col_pos];
        if (row_pos >= 1 && col_pos >= 1) begin
            total = longint'(left_above) + longint'(above) + longint'(left_here)
                  + longint'($signed(value));
            w.row = WIN_IDX_W'(row_pos - 1);
            w.col = WIN_IDX_W'(col_pos - 1);
            w.sum = SUM_W'(total);
            w.hit = (total > longint'(threshold_reg));
            window_q.push_back(w);
        end
        left_above        = above;
        left_here         = value;
        line_buf[col_pos] = value;
        if (col_pos + 1 > line_filled)
            line_filled = col_pos + 1;
        // position counters wrap at the configured sizes
        if (col_pos + 1 >= n_cols) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= n_rows) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endfunction

    function automatic void compare_field(input string tag, input longint want,
                                          input longint got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, tag, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_window();
        window_t              want;
        logic [M_TDATA_W-1:0] got;
        got = m_axis_tdata;
        if (window_q.size() == 0) begin
            $display("%0t ns: result with none expected, got row %0d col %0d sum %0d hit %0b",
                     $time, got[WIN_IDX_W-1:0], got[WIN_IDX_W +: WIN_IDX_W],
                     $signed(got[2*WIN_IDX_W +: SUM_W]), m_axis_tuser);
            mismatches++;
        end else begin
            want = window_q.pop_front();
            compare_field("win_row", want.row, got[WIN_IDX_W-1:0]);
            compare_field("win_col", want.col, got[WIN_IDX_W +: WIN_IDX_W]);
            compare_field("win_sum", longint'(want.sum),
                          longint'($signed(got[2*WIN_IDX_W +: SUM_W])));
            compare_field("hit", want.hit, m_axis_tuser);
            compare_field("tdata pad", 0, got[M_TDATA_W-1:2*WIN_IDX_W+SUM_W]);
        end
    endfunction

    // monitor: sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_window(s_axis_tdata);
                elem_taken  = 1'b1;
                elems_taken = elems_taken + 1;
            end
            if (m_axis_tvalid && m_axis_tready)
                check_window();
        end
    end

    // driver: element channel and result backpressure, updated at the falling edge
    always @(negedge i_clk) begin : drive_stream
        logic                 nxt_valid;
        logic [S_TDATA_W-1:0] nxt_data;
        nxt_valid  = s_axis_tvalid && !elem_taken;
        nxt_data   = s_axis_tdata;
        elem_taken = 1'b0;
        if (!nxt_valid && i_rst_n && elem_queue.size() != 0
                && $urandom_range(99) >= tx_idle_pct) begin
            nxt_data  = elem_queue.pop_front();
            nxt_valid = 1'b1;
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata  <= nxt_data;
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic feed(input logic [VAL_W-1:0] value);
        elem_queue.push_back(value);
        elems_queued++;
    endtask

    // wait for the stream to drain, then let the pipeline empty
    task automatic settle();
        while (elems_taken != elems_queued || window_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // one register transfer; valid stays up until close_writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_THRESHOLD: threshold_reg = data;
            CFG_COLS:      cols_reg      = data[SIZE_W-1:0];
            CFG_ROWS:      rows_reg      = data[SIZE_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic close_writes();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // widening past the filled part of the line buffer is only legal on row 0
    task automatic write_cols(input logic [SIZE_W-1:0] raw);
        logic [SIZE_W-1:0] safe;
        safe = raw;
        if (row_pos != 0 && size_eff(raw, COL_LIMIT) > line_filled)
            safe = SIZE_W'(line_filled);
        write_reg(CFG_COLS, {(CFG_DATA_W-SIZE_W)'($urandom()), safe});
    endtask

    function automatic logic [VAL_W-1:0] pick_value(input value_mix_t mix);
        value_mix_t m;
        m = (mix == VALS_MIXED) ? value_mix_t'($urandom_range(2)) : mix;
        case (m)
            VALS_NEAR_ZERO: return VAL_W'(int'($urandom_range(12)) - 6);
            VALS_EDGE: begin
                case ($urandom_range(3))
                    0:       return VAL_MAX;
                    1:       return VAL_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default:        return $urandom();
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_threshold();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return $urandom();
        if (r < 75)
            return VAL_W'(int'($urandom_range(40)) - 20);
        return $urandom_range(1) ? VAL_MAX : VAL_MIN;
    endfunction

    // mostly small sizes, now and then zero, mid-range or at or above the limit
    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return SIZE_W'($urandom_range(2, 8));
        if (r < 80)
            return SIZE_W'($urandom_range(1));
        if (r < 93)
            return SIZE_W'($urandom_range(9, 40));
        return SIZE_W'($urandom_range(1024, 2047));
    endfunction

    initial begin
        int         n;
        int         n_cols;
        int         n_rows;
        int         random_items;
        value_mix_t mix;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_THRESHOLD;
        i_cfg_data    = '0;
        random_items  = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // saturated sums: all maximum, half and half, all minimum
        write_reg(CFG_SPARE, $urandom());
        write_reg(CFG_THRESHOLD, VAL_MAX);
        write_reg(CFG_COLS, 32'd3);
        write_reg(CFG_ROWS, 32'h7FF);
        close_writes();
        repeat (6) feed(VAL_MAX);
        repeat (6) feed(VAL_MIN);
        settle();

        // zero column count acts as one column: rows advance, no windows
        write_reg(CFG_THRESHOLD, VAL_MIN);
        write_cols(11'd0);
        close_writes();
        feed('0);
        feed('1);
        settle();

        // shrink rows below the current row: one more window, then wrap to row 0
        write_reg(CFG_ROWS, 32'd0);
        write_cols(11'd2);
        close_writes();
        feed(32'd5);
        feed(-32'sd7);
        feed(32'd9);
        feed(32'd1);
        settle();

        // sum equal to threshold does not hit, one above does
        write_reg(CFG_THRESHOLD, 32'd10);
        write_reg(CFG_ROWS, 32'd2);
        close_writes();
        feed(32'd1); feed(32'd2); feed(32'd3); feed(32'd4);
        feed(32'd1); feed(32'd2); feed(32'd3); feed(32'd5);
        settle();

        // wide matrix, two rows: a long line buffer run
        write_reg(CFG_THRESHOLD, $urandom());
        write_reg(CFG_ROWS, 32'd2);
        write_cols(SIZE_W'(WIDE_COLS));
        close_writes();
        repeat (2 * WIDE_COLS) feed($urandom());
        settle();

        // random phases: resizing and threshold changes between them
        while (random_items < RANDOM_ITEMS) begin
            if (random_items < RANDOM_ITEMS / 3) begin
                tx_idle_pct = 37;
                rx_idle_pct = 62;
            end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 62;
                rx_idle_pct = 37;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            mix = value_mix_t'($urandom_range(3));
            if ($urandom_range(1))
                write_reg(CFG_THRESHOLD, pick_threshold());
            if ($urandom_range(1))
                write_cols(pick_size());
            if ($urandom_range(1))
                write_reg(CFG_ROWS, {(CFG_DATA_W-SIZE_W)'($urandom()), pick_size()});
            close_writes();
            n_cols = size_eff(cols_reg, COL_LIMIT);
            n_rows = size_eff(rows_reg, ROW_LIMIT);
            // either finish the current matrix or run a random number of elements; long runs are cut short
            if ($urandom_range(1) && row_pos < n_rows && col_pos < n_cols)
                n = n_rows * n_cols - (row_pos * n_cols + col_pos);
            else
                n = $urandom_range(4, 60);
            if (n > 120)
                n = $urandom_range(60, 120);
            repeat (n) feed(pick_value(mix));
            random_items += n;
            settle();
        end

        if (mismatches == 0 && window_q.size() == 0) begin
            $display("window2x2_sum_threshold_top verification clean");
        end else begin
            $display("window2x2_sum_threshold_top verification failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("window2x2_sum_threshold_top verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/w2s_pkg.sv
rtl/core/w2s_ram.sv
rtl/core/w2s_fifo.sv
rtl/core/w2s_front.sv
rtl/core/w2s_back.sv
rtl/core/window2x2_sum_threshold_top.sv
rtl/core/w2s_checker.sv
test/tb_window2x2_sum_threshold_top.sv
